@@ rtl/stpf_pkg.sv @@
package stpf_pkg;

  // Command codes carried in the input tuser
  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_FLUSH = 3'd2,
    CMD_ABORT = 3'd3,
    CMD_START = 3'd4
  } cmd_e;

  // Result status codes carried in the output tuser
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_RETRY   = 3'd2,
    ST_ABORTED = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // Effect of one item on the byte and duration totals
  typedef enum logic [1:0] {
    TOT_NONE  = 2'd0,
    TOT_ADD   = 2'd1,
    TOT_SUB   = 2'd2,
    TOT_CLEAR = 2'd3
  } tot_op_e;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned DUR_W    = 32;
  localparam int unsigned STREAM_W = 8;
  localparam int unsigned SERIAL_W = 16;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned TOTAL_W  = 40;
  localparam int unsigned OVH_W    = 12;

  // Packet descriptor as it arrives
  typedef struct packed {
    logic                is_flush;
    logic [STREAM_W-1:0] stream;
    logic [DUR_W-1:0]    duration;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } pkt_t;

  // Stored queue entry
  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    pkt_t                pkt;
  } entry_t;

  // Per-item result info from the control stage
  typedef struct packed {
    status_e             status;
    tot_op_e             op;
    logic [SIZE_W-1:0]   size;
    logic [DUR_W-1:0]    duration;
    logic [COUNT_W-1:0]  count;
    logic [SERIAL_W-1:0] serial;
  } meta_t;

endpackage

@@ rtl/serial_tagged_packet_fifo.sv @@
// Channel   Dir  Handshake                  Payload
// --------  ---  -------------------------  ---------------------------------------------
// command   in   s_axis_tvalid/tready       tuser: command; tdata: packet descriptor
// result    out  m_axis_tvalid/tready       tuser: status; tdata: entry, count, totals
// overhead  in   cfg_we_i (no wait)         cfg_wdata_i: per-entry byte overhead
//
// One item per cycle while the output is not stalled; a result passes the stage 1 and output registers.
// Stage 1 updates pointers, count and serial and reads the head entry from the store;
// stage 2 applies the byte and duration totals once the read data is back.
// Reset clears all control state and sets the abort flag; the store is not cleared.
// A stalled output holds its result; stage 1 keeps one more, then tready drops.
module serial_tagged_packet_fifo import stpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [OVH_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] pkt_handle, [55:32] pkt_size, [87:56] pkt_duration, [95:88] pkt_stream,
  // [96] is_flush_marker, [97] wait_if_empty, [103:98] zero
  input  logic [103:0]     s_axis_tdata,
  // [2:0] command
  input  logic [2:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [31:0] out_handle, [55:32] out_size, [87:56] out_duration, [95:88] out_stream,
  // [111:96] out_serial, [112] out_is_flush, [121:113] packet_count,
  // [161:122] byte_total, [201:162] duration_total, [217:202] current_serial, [223:218] zero
  output logic [223:0]     m_axis_tdata,
  // [2:0] status
  output logic [2:0]       m_axis_tuser
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic [OVH_W-1:0]   ovh_q;
  logic               accept, s1_adv;
  logic               s1_v_q, s2_v_q;
  meta_t              meta, s1_meta_q;
  pkt_t               in_pkt;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic               is_get;
  entry_t             out_entry;
  logic [SIZE_W-1:0]  tot_size;
  logic [DUR_W-1:0]   tot_dur;
  logic [TOTAL_W-1:0] bytes_next, dur_next;
  logic [223:0]       s2_data_q;
  logic [2:0]         s2_status_q;

  // Overhead register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q <= '0;
    end else if (cfg_we_i) begin
      ovh_q <= cfg_wdata_i;
    end
  end

  // Handshake: stage 1 frees up whenever stage 2 can take its item
  assign s1_adv        = s1_v_q && (!s2_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_pkt = '{
    is_flush: s_axis_tdata[96],
    stream:   s_axis_tdata[95:88],
    duration: s_axis_tdata[87:56],
    size:     s_axis_tdata[55:32],
    handle:   s_axis_tdata[31:0]
  };

  stpf_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(accept),
    .cmd_i      (s_axis_tuser),
    .pkt_i      (in_pkt),
    .wait_i     (s_axis_tdata[97]),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .meta_o     (meta)
  );

  stpf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Stage 1 register; read data lines up with it in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
  end

  // Dequeued entry only on a successful get
  assign is_get    = (s1_meta_q.op == TOT_SUB);
  assign out_entry = is_get ? ram_rdata : '0;
  assign tot_size  = is_get ? ram_rdata.pkt.size : s1_meta_q.size;
  assign tot_dur   = is_get ? ram_rdata.pkt.duration : s1_meta_q.duration;

  stpf_totals u_totals (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .op_i   (s1_meta_q.op),
    .size_i (tot_size),
    .dur_i  (tot_dur),
    .ovh_i  (ovh_q),
    .bytes_o(bytes_next),
    .dur_o  (dur_next)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      s2_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_status_q <= s1_meta_q.status;
      s2_data_q   <= {6'd0, s1_meta_q.serial, dur_next, bytes_next, s1_meta_q.count,
                      out_entry.pkt.is_flush, out_entry.serial, out_entry.pkt.stream,
                      out_entry.pkt.duration, out_entry.pkt.size, out_entry.pkt.handle};
    end
  end

  assign m_axis_tvalid = s2_v_q;
  assign m_axis_tdata  = s2_data_q;
  assign m_axis_tuser  = s2_status_q;

endmodule

@@ rtl/stpf_ram.sv @@
module stpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/stpf_ctrl.sv @@
module stpf_ctrl import stpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  logic [2:0]    cmd_i,
  input  pkt_t          pkt_i,
  input  logic          wait_i,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output entry_t        ram_wdata_o,
  output logic          ram_re_o,
  output logic [AW-1:0] ram_raddr_o,
  output meta_t         meta_o
);

  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

  logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SERIAL_W-1:0] serial_q, serial_d;
  logic                abort_q, abort_d;
  status_e             status;
  tot_op_e             op;

  // Command decode and queue bookkeeping
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    serial_d = serial_q;
    abort_d  = abort_q;
    status   = ST_OK;
    op       = TOT_NONE;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;
    if (cmd_valid_i) begin
      unique case (cmd_i)
        CMD_PUT: begin
          if (abort_q) begin
            status = ST_ABORTED;
          end else if (count_q == FullCount) begin
            status = ST_FULL;
          end else begin
            serial_d = serial_q + SERIAL_W'(pkt_i.is_flush);
            ram_we_o = 1'b1;
            tail_d   = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
            count_d  = count_q + 1'b1;
            op       = TOT_ADD;
          end
        end
        CMD_GET: begin
          if (abort_q) begin
            status = ST_ABORTED;
          end else if (count_q == '0) begin
            status = wait_i ? ST_RETRY : ST_EMPTY;
          end else begin
            ram_re_o = 1'b1;
            head_d   = (head_q == LastSlot) ? '0 : head_q + 1'b1;
            count_d  = count_q - 1'b1;
            op       = TOT_SUB;
          end
        end
        CMD_FLUSH: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
          op      = TOT_CLEAR;
        end
        CMD_ABORT: abort_d = 1'b1;
        CMD_START: abort_d = 1'b0;
        default: ;
      endcase
    end
  end

  assign ram_waddr_o = tail_q;
  assign ram_raddr_o = head_q;
  assign ram_wdata_o = '{serial: serial_d, pkt: pkt_i};

  assign meta_o = '{
    status:   status,
    op:       op,
    size:     pkt_i.size,
    duration: pkt_i.duration,
    count:    COUNT_W'(count_d),
    serial:   serial_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      serial_q <= '0;
      abort_q  <= 1'b1;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      serial_q <= serial_d;
      abort_q  <= abort_d;
    end
  end

  // Empty or full queue means the pointers meet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCount) |-> head_q == tail_q)
    else $error("pointers disagree with count");

  // Nothing touches the store while aborted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    abort_q |-> (!ram_we_o && !ram_re_o))
    else $error("store access while aborted");

  // Serial only moves on a stored flush marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (serial_d != serial_q) |-> (ram_we_o && pkt_i.is_flush))
    else $error("serial moved without stored flush marker");

endmodule

@@ rtl/stpf_totals.sv @@
module stpf_totals import stpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tot_op_e            op_i,
  input  logic [SIZE_W-1:0]  size_i,
  input  logic [DUR_W-1:0]   dur_i,
  input  logic [OVH_W-1:0]   ovh_i,
  output logic [TOTAL_W-1:0] bytes_o,
  output logic [TOTAL_W-1:0] dur_o
);

  logic [TOTAL_W-1:0] bytes_q, bytes_d, dur_q, dur_d;
  logic [SIZE_W:0]    charge;

  // Size plus per-entry overhead, then one add, subtract or clear per total
  assign charge = {1'b0, size_i} + (SIZE_W + 1)'(ovh_i);

  always_comb begin
    case (op_i)
      TOT_ADD: begin
        bytes_d = bytes_q + TOTAL_W'(charge);
        dur_d   = dur_q + TOTAL_W'(dur_i);
      end
      TOT_SUB: begin
        bytes_d = bytes_q - TOTAL_W'(charge);
        dur_d   = dur_q - TOTAL_W'(dur_i);
      end
      TOT_CLEAR: begin
        bytes_d = '0;
        dur_d   = '0;
      end
      default: begin
        bytes_d = bytes_q;
        dur_d   = dur_q;
      end
    endcase
  end

  assign bytes_o = bytes_d;
  assign dur_o   = dur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      dur_q   <= '0;
    end else if (step_i) begin
      bytes_q <= bytes_d;
      dur_q   <= dur_d;
    end
  end

endmodule
